>>> rtl/ttt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_pkg
// Types, constants and register indexes for the three-level thermal throttle.
// ----------------------------------------------------------------------------
package ttt_pkg;

	localparam int TEMP_W  = 8;
	localparam int CORE_W  = 3;
	localparam int FREQ_W  = 22;
	localparam int LEVEL_W = 2;
	localparam int INDEX_W = 3;
	localparam int DATA_W  = FREQ_W;

	typedef logic [TEMP_W-1:0]  temp_t;
	typedef logic [CORE_W-1:0]  core_t;
	typedef logic [FREQ_W-1:0]  freq_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [INDEX_W-1:0] cfg_index_t;
	typedef logic [DATA_W-1:0]  cfg_data_t;

	// throttle levels
	localparam level_t LEVEL_NONE = 2'd0;
	localparam level_t LEVEL_LOW  = 2'd1;
	localparam level_t LEVEL_MID  = 2'd2;
	localparam level_t LEVEL_MAX  = 2'd3;

	// register indexes
	localparam cfg_index_t REG_LOW_TRIP_TEMP  = 3'd0;
	localparam cfg_index_t REG_LOW_CLEAR_TEMP = 3'd1;
	localparam cfg_index_t REG_LOW_LEVEL_FREQ = 3'd2;
	localparam cfg_index_t REG_MID_TRIP_TEMP  = 3'd3;
	localparam cfg_index_t REG_MID_CLEAR_TEMP = 3'd4;
	localparam cfg_index_t REG_MID_LEVEL_FREQ = 3'd5;
	localparam cfg_index_t REG_MAX_TRIP_TEMP  = 3'd6;
	localparam cfg_index_t REG_MAX_LEVEL_FREQ = 3'd7;

	// register reset values
	localparam temp_t RST_LOW_TRIP_TEMP  = 8'd70;
	localparam temp_t RST_LOW_CLEAR_TEMP = 8'd64;
	localparam freq_t RST_LOW_LEVEL_FREQ = 22'd972000;
	localparam temp_t RST_MID_TRIP_TEMP  = 8'd72;
	localparam temp_t RST_MID_CLEAR_TEMP = 8'd67;
	localparam freq_t RST_MID_LEVEL_FREQ = 22'd648000;
	localparam temp_t RST_MAX_TRIP_TEMP  = 8'd76;
	localparam freq_t RST_MAX_LEVEL_FREQ = 22'd384000;

	// fixed behavior
	localparam temp_t MAX_CLEAR_TEMP = 8'd71;
	localparam core_t RELEASE_CORE   = 3'd1;
	localparam freq_t FALLBACK_CAP   = 22'd1566000;

endpackage

>>> rtl/ttt_check_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_check_if
// Channel for one per-core temperature check.
// ----------------------------------------------------------------------------
interface ttt_check_if;
	import ttt_pkg::*;

	logic  valid;
	logic  ready;
	temp_t temperature;
	core_t core_index;
	freq_t current_cap;
	freq_t hardware_max;

	modport source (output valid, output temperature, output core_index,
		output current_cap, output hardware_max, input ready);
	modport sink (input valid, input temperature, input core_index,
		input current_cap, input hardware_max, output ready);

endinterface

>>> rtl/ttt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_result_if
// Channel for one throttle decision.
// ----------------------------------------------------------------------------
interface ttt_result_if;
	import ttt_pkg::*;

	logic   valid;
	logic   ready;
	logic   apply_cap;
	freq_t  new_cap;
	level_t level_after;

	modport source (output valid, output apply_cap, output new_cap,
		output level_after, input ready);
	modport sink (input valid, input apply_cap, input new_cap,
		input level_after, output ready);

endinterface

>>> rtl/three_level_thermal_throttle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_thermal_throttle
// Per-core throttle decision with three levels and hysteresis.
//
// check:  one item per core temperature check (temperature, core index,
//         present cap, hardware maximum), valid/ready.
// result: one item per check (apply flag, new cap, level after), valid/ready.
// config: wr_en/wr_index/wr_data write port for the eight thresholds and
//         level caps; write only while no check is in flight.
// An accepted item is held in an input register, decided there against the
// level and saved cap, and lands in the result register, which offers it.
// One item per cycle is taken and delivered while the receiver keeps up;
// the level/saved-cap update is made as the item enters the result register.
// When the receiver stalls, the result register holds and the input register
// fills; check.ready then drops until the result is taken.
// Reset clears level and saved cap, loads default thresholds and level caps,
// and empties both registers.
// ----------------------------------------------------------------------------
module three_level_thermal_throttle (
	input  logic                 clk,
	input  logic                 arst_n,
	ttt_check_if.sink            check,
	ttt_result_if.source         result,
	input  logic                 wr_en,
	input  ttt_pkg::cfg_index_t  wr_index,
	input  ttt_pkg::cfg_data_t   wr_data
);
	import ttt_pkg::*;

	// configuration
	temp_t low_trip_q, low_clear_q, mid_trip_q, mid_clear_q, max_trip_q;
	freq_t low_freq_q, mid_freq_q, max_freq_q;

	// state
	level_t level_q;
	freq_t  saved_cap_q;

	// input register
	logic  valid_s1;
	temp_t temp_s1;
	core_t core_s1;
	freq_t cur_s1;
	freq_t hw_s1;

	// result register
	logic   out_valid_q;
	logic   apply_q;
	freq_t  cap_q;
	level_t level_out_q;

	logic   adv;
	logic   release_core;
	logic   low_trip, low_clr, mid_trip, mid_clr, max_trip, max_clr;
	logic   raise_ok;
	logic   apply_d;
	freq_t  cap_d;
	level_t level_d;
	logic   save_d;

	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign check.ready  = !valid_s1 || adv;
	assign release_core = (core_s1 == RELEASE_CORE);
	assign raise_ok     = (cur_s1 < hw_s1);

	assign low_trip = (temp_s1 >= low_trip_q) && (temp_s1 < mid_trip_q) && (cur_s1 > low_freq_q);
	assign low_clr  = (temp_s1 < low_clear_q) && (level_q != LEVEL_NONE);
	assign mid_trip = (temp_s1 >= mid_trip_q) && (temp_s1 < max_trip_q) && (cur_s1 > mid_freq_q);
	assign mid_clr  = (temp_s1 < mid_clear_q) && (level_q > LEVEL_LOW);
	assign max_trip = (temp_s1 >= max_trip_q) && (cur_s1 > max_freq_q);
	assign max_clr  = (temp_s1 < MAX_CLEAR_TEMP) && (level_q == LEVEL_MAX);

	always_comb begin
		apply_d = 1'b0;
		cap_d   = '0;
		level_d = level_q;
		save_d  = 1'b0;
		if (low_trip) begin
			apply_d = 1'b1;
			cap_d   = low_freq_q;
			level_d = LEVEL_LOW;
			save_d  = 1'b1;
		end else if (low_clr) begin
			if (raise_ok) begin
				apply_d = 1'b1;
				cap_d   = (saved_cap_q != '0) ? saved_cap_q : FALLBACK_CAP;
				if (release_core) level_d = LEVEL_NONE;
			end
		end else if (mid_trip) begin
			apply_d = 1'b1;
			cap_d   = mid_freq_q;
			level_d = LEVEL_MID;
		end else if (mid_clr) begin
			if (raise_ok) begin
				apply_d = 1'b1;
				cap_d   = low_freq_q;
				if (release_core) level_d = LEVEL_LOW;
			end
		end else if (max_trip) begin
			apply_d = 1'b1;
			cap_d   = max_freq_q;
			level_d = LEVEL_MAX;
		end else if (max_clr) begin
			if (raise_ok) begin
				apply_d = 1'b1;
				cap_d   = mid_freq_q;
				if (release_core) level_d = LEVEL_MID;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_trip_q  <= RST_LOW_TRIP_TEMP;
			low_clear_q <= RST_LOW_CLEAR_TEMP;
			low_freq_q  <= RST_LOW_LEVEL_FREQ;
			mid_trip_q  <= RST_MID_TRIP_TEMP;
			mid_clear_q <= RST_MID_CLEAR_TEMP;
			mid_freq_q  <= RST_MID_LEVEL_FREQ;
			max_trip_q  <= RST_MAX_TRIP_TEMP;
			max_freq_q  <= RST_MAX_LEVEL_FREQ;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LOW_TRIP_TEMP:  low_trip_q  <= wr_data[TEMP_W-1:0];
				REG_LOW_CLEAR_TEMP: low_clear_q <= wr_data[TEMP_W-1:0];
				REG_LOW_LEVEL_FREQ: low_freq_q  <= wr_data[FREQ_W-1:0];
				REG_MID_TRIP_TEMP:  mid_trip_q  <= wr_data[TEMP_W-1:0];
				REG_MID_CLEAR_TEMP: mid_clear_q <= wr_data[TEMP_W-1:0];
				REG_MID_LEVEL_FREQ: mid_freq_q  <= wr_data[FREQ_W-1:0];
				REG_MAX_TRIP_TEMP:  max_trip_q  <= wr_data[TEMP_W-1:0];
				REG_MAX_LEVEL_FREQ: max_freq_q  <= wr_data[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (check.ready) begin
			valid_s1 <= check.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (check.valid && check.ready) begin
			temp_s1 <= check.temperature;
			core_s1 <= check.core_index;
			cur_s1  <= check.current_cap;
			hw_s1   <= check.hardware_max;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_NONE;
			saved_cap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				level_q <= level_d;
				if (save_d) saved_cap_q <= cur_s1;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			apply_q     <= apply_d;
			cap_q       <= cap_d;
			level_out_q <= level_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.apply_cap   = apply_q;
	assign result.new_cap     = cap_q;
	assign result.level_after = level_out_q;

	// level only moves when an item is decided
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(level_q))
		else $error("throttle level changed without a decided item");

	// a clear lowers the level only on the release core
	a_release_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !release_core && !low_trip && !mid_trip |=> level_q >= $past(level_q))
		else $error("throttle level dropped on a non-release core");

	// no cap without apply
	a_cap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !apply_q |-> cap_q == '0)
		else $error("new cap nonzero while apply is low");

	// the reported level matches the kept level for the newest item
	a_level_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> level_out_q == level_q)
		else $error("reported level differs from kept level");

endmodule
